@@ hw/rtl/ll1_expression_parser_assert.svh @@
// assertion macros for the ll1 expression parser
`ifndef LL1_EXPRESSION_PARSER_ASSERT_SVH
`define LL1_EXPRESSION_PARSER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define LL1EP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ll1 parser check failed");

// next-cycle implication, disabled during reset
`define LL1EP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ll1 parser check failed");

`else

`define LL1EP_ASSERT_NOW(label, clk, rstn, ante, cons)
`define LL1EP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/ll1ep_pkg.sv @@
// shared types, codes and helpers for the ll1 expression parser
`default_nettype none

package ll1ep_pkg;

    localparam int STACK_DEPTH_DEF = 8;

    // token bytes of the four terminals
    localparam logic [7:0] CHR_END  = 8'h24;   // '$'
    localparam logic [7:0] CHR_PLUS = 8'h2B;   // '+'
    localparam logic [7:0] CHR_STAR = 8'h2A;   // '*'
    localparam logic [7:0] CHR_ID   = 8'h69;   // 'i'

    // grammar symbol codes held in the stack cells
    typedef enum logic [3:0] {
        SYM_END  = 4'd0,
        SYM_E    = 4'd1,
        SYM_A    = 4'd2,
        SYM_T    = 4'd3,
        SYM_B    = 4'd4,
        SYM_F    = 4'd5,
        SYM_PLUS = 4'd6,
        SYM_STAR = 4'd7,
        SYM_ID   = 4'd8
    } sym_t;

    localparam logic [3:0] TOK_NONE = 4'hF;

    typedef enum logic [2:0] {
        ST_CONSUMED = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_REJECT   = 3'd2,
        ST_ERROR    = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // stack row operations
    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_WRITE = 3'd1,
        OP_PUSH  = 3'd2,
        OP_POP   = 3'd3,
        OP_INIT  = 3'd4
    } stack_op_t;

    // command broadcast to the cell row
    typedef struct packed {
        stack_op_t op;
        sym_t      top_sym;
        sym_t      under_sym;
    } stack_cmd_t;

    // terminal code of a token byte
    function automatic logic [3:0] token_code(input logic [7:0] tok);
        logic [3:0] code;
        case (tok)
            CHR_END:  code = SYM_END;
            CHR_PLUS: code = SYM_PLUS;
            CHR_STAR: code = SYM_STAR;
            CHR_ID:   code = SYM_ID;
            default:  code = TOK_NONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ll1ep_cell.sv @@
// one cell of the symbol stack row
`default_nettype none

module ll1ep_cell #(
    parameter ll1ep_pkg::sym_t INIT_SYM = ll1ep_pkg::SYM_END,
    parameter bit              TOP_CELL = 1'b0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ll1ep_pkg::stack_cmd_t cmd,
    input  wire ll1ep_pkg::sym_t       upper_sym,
    input  wire ll1ep_pkg::sym_t       lower_sym,
    output ll1ep_pkg::sym_t            sym
);

    ll1ep_pkg::sym_t sym_reg;
    ll1ep_pkg::sym_t sym_next;

    always_comb begin
        sym_next = sym_reg;
        unique case (cmd.op)
            ll1ep_pkg::OP_HOLD:  sym_next = sym_reg;
            ll1ep_pkg::OP_WRITE: sym_next = TOP_CELL ? upper_sym : sym_reg;
            ll1ep_pkg::OP_PUSH:  sym_next = upper_sym;
            ll1ep_pkg::OP_POP:   sym_next = lower_sym;
            ll1ep_pkg::OP_INIT:  sym_next = INIT_SYM;
            default:             sym_next = sym_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg <= INIT_SYM;
        end else begin
            sym_reg <= sym_next;
        end
    end

    assign sym = sym_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ll1_expression_parser.sv @@
// top level of the ll1 expression parser: controller, stack cell row, result register
`default_nettype none

// Table-driven LL(1) parser for E->TA, A->+TA|e, T->FB, B->*FB|e, F->i. Each
// input word is one token byte ('i', '+', '*', '$'; anything else is invalid)
// and each yields one result word with a status (consumed, accepted, rejected,
// syntax error, stack overflow) and the number of productions applied for that
// token, saturating at 15. The symbol stack is a row of STACK_DEPTH cells with
// the top in cell 0; a push writes cells 0 and 1 and shifts the rest one place
// down, a pop shifts every cell one place up. After any status other than
// consumed the stack returns to $ E. A token is taken in, then each production
// is applied in turn (A->+TA and B->*FB push twice through the row), then the
// match or final decision is made; no new token is taken before that. The final
// decision waits while the result register still holds an unaccepted word. A
// finished result waits in the output register while the next token is taken in.
module ll1_expression_parser #(
    parameter int STACK_DEPTH = ll1ep_pkg::STACK_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // token stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] token
    // result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [2:0] status, [6:3] expansions, [7] zero
);

`include "ll1_expression_parser_assert.svh"

    localparam int SP_W = $clog2(STACK_DEPTH);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_PUSH2 = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]      tc_reg, tc_next;       // terminal code of current token
    logic [3:0]      cnt_reg, cnt_next;     // productions applied so far
    logic [SP_W-1:0] sp_reg, sp_next;       // index of the end-marker cell

    // second push of a three-symbol production
    ll1ep_pkg::sym_t push2_top_reg, push2_top_next;
    ll1ep_pkg::sym_t push2_under_reg, push2_under_next;

    // result register
    logic                 m_tvalid_reg;
    ll1ep_pkg::status_t   m_status_reg;
    logic [3:0]           m_expansions_reg;

    ll1ep_pkg::stack_cmd_t cmd;
    ll1ep_pkg::sym_t       stack_sym [STACK_DEPTH];
    ll1ep_pkg::sym_t       top;

    logic               out_free;
    logic               fire_out;
    ll1ep_pkg::status_t fin_status;
    logic               in_fire;

    assign top      = stack_sym[0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // ---------------------------------------------------------------------
    // controller: one production step or decision per cycle; decisions can stall
    // ---------------------------------------------------------------------
    always_comb begin
        logic fin;
        logic sat;
        fin              = 1'b0;
        sat              = (cnt_reg == 4'hF);
        fin_status       = ll1ep_pkg::ST_CONSUMED;
        fire_out         = 1'b0;
        state_next       = state_reg;
        tc_next          = tc_reg;
        cnt_next         = cnt_reg;
        sp_next          = sp_reg;
        push2_top_next   = push2_top_reg;
        push2_under_next = push2_under_reg;
        cmd.op           = ll1ep_pkg::OP_HOLD;
        cmd.top_sym      = top;
        cmd.under_sym    = top;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    tc_next    = ll1ep_pkg::token_code(s_tdata);
                    cnt_next   = 4'd0;
                    state_next = S_EVAL;
                end
            end

            S_EVAL: begin
                if (top == ll1ep_pkg::SYM_END) begin
                    fin        = 1'b1;
                    fin_status = (tc_reg == ll1ep_pkg::SYM_END) ? ll1ep_pkg::ST_ACCEPT
                                                                : ll1ep_pkg::ST_REJECT;
                end else if (top == tc_reg) begin
                    // terminal matches: pop and report consumed
                    fin        = 1'b1;
                    fin_status = ll1ep_pkg::ST_CONSUMED;
                end else begin
                    case (top) inside
                        ll1ep_pkg::SYM_E, ll1ep_pkg::SYM_T: begin
                            // two-symbol production, top becomes T or F
                            if (sp_reg == SP_W'(STACK_DEPTH - 1)) begin
                                fin        = 1'b1;
                                fin_status = ll1ep_pkg::ST_OVERFLOW;
                            end else begin
                                cmd.op        = ll1ep_pkg::OP_PUSH;
                                cmd.top_sym   = (top == ll1ep_pkg::SYM_E) ? ll1ep_pkg::SYM_T
                                                                          : ll1ep_pkg::SYM_F;
                                cmd.under_sym = (top == ll1ep_pkg::SYM_E) ? ll1ep_pkg::SYM_A
                                                                          : ll1ep_pkg::SYM_B;
                                sp_next       = sp_reg + 1'b1;
                                cnt_next      = sat ? cnt_reg : cnt_reg + 1'b1;
                            end
                        end
                        ll1ep_pkg::SYM_A, ll1ep_pkg::SYM_B: begin
                            if ((top == ll1ep_pkg::SYM_A && tc_reg == ll1ep_pkg::SYM_PLUS) ||
                                (top == ll1ep_pkg::SYM_B && tc_reg == ll1ep_pkg::SYM_STAR))
                            begin
                                // three-symbol production over two pushes
                                if (sp_reg >= SP_W'(STACK_DEPTH - 2)) begin
                                    fin        = 1'b1;
                                    fin_status = ll1ep_pkg::ST_OVERFLOW;
                                end else begin
                                    cmd.op        = ll1ep_pkg::OP_PUSH;
                                    cmd.under_sym = top;
                                    if (top == ll1ep_pkg::SYM_A) begin
                                        cmd.top_sym      = ll1ep_pkg::SYM_T;
                                        push2_top_next   = ll1ep_pkg::SYM_PLUS;
                                        push2_under_next = ll1ep_pkg::SYM_T;
                                    end else begin
                                        cmd.top_sym      = ll1ep_pkg::SYM_F;
                                        push2_top_next   = ll1ep_pkg::SYM_STAR;
                                        push2_under_next = ll1ep_pkg::SYM_F;
                                    end
                                    sp_next    = sp_reg + 1'b1;
                                    cnt_next   = sat ? cnt_reg : cnt_reg + 1'b1;
                                    state_next = S_PUSH2;
                                end
                            end else begin
                                // empty production
                                cmd.op   = ll1ep_pkg::OP_POP;
                                sp_next  = (sp_reg != '0) ? sp_reg - 1'b1 : sp_reg;
                                cnt_next = sat ? cnt_reg : cnt_reg + 1'b1;
                            end
                        end
                        ll1ep_pkg::SYM_F: begin
                            if (tc_reg == ll1ep_pkg::SYM_ID) begin
                                cmd.op      = ll1ep_pkg::OP_WRITE;
                                cmd.top_sym = ll1ep_pkg::SYM_ID;
                                cnt_next    = sat ? cnt_reg : cnt_reg + 1'b1;
                            end else begin
                                fin        = 1'b1;
                                fin_status = ll1ep_pkg::ST_ERROR;
                            end
                        end
                        default: begin
                            // terminal mismatch or unknown code
                            fin        = 1'b1;
                            fin_status = ll1ep_pkg::ST_ERROR;
                        end
                    endcase
                end

                // a final decision waits until the result register is free
                if (fin) begin
                    if (out_free) begin
                        fire_out   = 1'b1;
                        state_next = S_IDLE;
                        if (fin_status == ll1ep_pkg::ST_CONSUMED) begin
                            cmd.op  = ll1ep_pkg::OP_POP;
                            sp_next = (sp_reg != '0) ? sp_reg - 1'b1 : sp_reg;
                        end else begin
                            cmd.op  = ll1ep_pkg::OP_INIT;
                            sp_next = SP_W'(1);
                        end
                    end else begin
                        cmd.op = ll1ep_pkg::OP_HOLD;
                    end
                end
            end

            S_PUSH2: begin
                cmd.op        = ll1ep_pkg::OP_PUSH;
                cmd.top_sym   = push2_top_reg;
                cmd.under_sym = push2_under_reg;
                sp_next       = sp_reg + 1'b1;
                state_next    = S_EVAL;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sp_reg       <= SP_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (fire_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tc_reg          <= tc_next;
        cnt_reg         <= cnt_next;
        push2_top_reg   <= push2_top_next;
        push2_under_reg <= push2_under_next;
        if (fire_out) begin
            m_status_reg     <= fin_status;
            m_expansions_reg <= cnt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_expansions_reg, m_status_reg};

    // ---------------------------------------------------------------------
    // symbol stack: row of cells, top in cell 0
    // ---------------------------------------------------------------------
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        ll1ep_pkg::sym_t upper_in;
        ll1ep_pkg::sym_t lower_in;

        if (k == 0) begin : g_top
            assign upper_in = cmd.top_sym;
        end else if (k == 1) begin : g_second
            assign upper_in = cmd.under_sym;
        end else begin : g_rest
            assign upper_in = stack_sym[k-1];
        end

        if (k == STACK_DEPTH - 1) begin : g_bottom
            assign lower_in = ll1ep_pkg::SYM_END;
        end else begin : g_inner
            assign lower_in = stack_sym[k+1];
        end

        ll1ep_cell #(
            .INIT_SYM ((k == 0) ? ll1ep_pkg::SYM_E : ll1ep_pkg::SYM_END),
            .TOP_CELL ((k == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .upper_sym (upper_in),
            .lower_sym (lower_in),
            .sym       (stack_sym[k])
        );
    end

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    logic reinit_due;
    logic at_start;
    logic push2_top_ok;

    assign reinit_due   = fire_out && (fin_status != ll1ep_pkg::ST_CONSUMED);
    assign at_start     = (stack_sym[0] == ll1ep_pkg::SYM_E) && (sp_reg == SP_W'(1));
    assign push2_top_ok = (stack_sym[0] == ll1ep_pkg::SYM_T) || (stack_sym[0] == ll1ep_pkg::SYM_F);

    // a final status other than consumed leaves the stack at $ E
    `LL1EP_ASSERT_NEXT(a_reinit, aclk, aresetn, reinit_due, at_start)
    // an empty stack shows the end marker on top
    `LL1EP_ASSERT_NOW(a_bottom_end, aclk, aresetn, sp_reg == '0, stack_sym[0] == ll1ep_pkg::SYM_END)
    // the second push follows a first push of T or F
    `LL1EP_ASSERT_NOW(a_push2_top, aclk, aresetn, state_reg == S_PUSH2, push2_top_ok)
    // a taken token is worked on before the next one is taken
    `LL1EP_ASSERT_NEXT(a_one_token, aclk, aresetn, in_fire, !s_tready)

endmodule

`default_nettype wire
